@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the hash block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("Assertion failed.");

// Next-cycle implication, disabled while reset is asserted.
`define CSH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("Assertion failed.");

`endif

@@ rtl/csh_pkg.sv @@
package csh_pkg;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned SHIFT_W = 6;

	localparam logic [CFG_INDEX_W-1:0] REG_SEED_PRIMARY = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SEED_SECONDARY = 2'd1;

	localparam logic [27:0] P_MUL_T = 28'd15485077;
	localparam logic [27:0] P_MUL_X = 28'd12338621;
	localparam logic [27:0] P_MUL_Y = 28'd15485863;
	localparam logic [27:0] P_MUL_Z = 28'd14416417;
	localparam logic [27:0] Q_MUL_T = 28'd179424743;
	localparam logic [27:0] Q_MUL_Y = 28'd154858637;
	localparam logic [27:0] Q_MUL_X = 28'd179426003;
	localparam logic [27:0] Q_MUL_Z = 28'd179425819;

	localparam int unsigned P_MOD_X = 13;
	localparam int unsigned P_MOD_Y = 11;
	localparam int unsigned P_MOD_Z = 7;
	localparam int unsigned P_MOD_T = 17;
	localparam int unsigned Q_MOD_X = 29;
	localparam int unsigned Q_MOD_Y = 31;
	localparam int unsigned Q_MOD_Z = 23;
	localparam int unsigned Q_MOD_T = 43;

	localparam logic [SHIFT_W-1:0] P_OFF_X = 6'd5;
	localparam logic [SHIFT_W-1:0] P_OFF_Y = 6'd28;
	localparam logic [SHIFT_W-1:0] P_OFF_Z = 6'd13;
	localparam logic [SHIFT_W-1:0] P_OFF_T = 6'd45;
	localparam logic [SHIFT_W-1:0] Q_OFF_X = 6'd13;
	localparam logic [SHIFT_W-1:0] Q_OFF_Y = 6'd7;
	localparam logic [SHIFT_W-1:0] Q_OFF_Z = 6'd19;
	localparam logic [SHIFT_W-1:0] Q_OFF_T = 6'd11;

	typedef struct packed {
		logic [SHIFT_W-1:0] sh1;
		logic [SHIFT_W-1:0] sh2;
		logic [SHIFT_W-1:0] sh3;
		logic [SHIFT_W-1:0] sh4;
	} csh_shifts_t;

	function automatic logic [63:0] shr_arith(input logic [63:0] v, input logic [SHIFT_W-1:0] s);
		return $unsigned($signed(v) >>> s);
	endfunction

	function automatic logic [63:0] mul_ext(input logic signed [31:0] c, input logic [27:0] k);
		logic signed [60:0] prod;
		prod = c * $signed({1'b0, k});
		return {{3{prod[60]}}, prod};
	endfunction

endpackage

@@ rtl/seeded_coordinate_hash.sv @@
// Seeded 64-bit hash of a point in three- or four-dimensional integer space.
// Seeds are written through the cfg channel: cfg_index selects seed_primary
// (0) or seed_secondary (1), other indexes are ignored; cfg_ready is always
// high. Seeds should only be changed while no beat is in flight.
// A beat on the item channel carries kind and the four coordinates; each one
// yields exactly one beat on the hash channel, in order.
// The pipeline has six register stages (product, two adder stages, one
// alignment stage, then two xorshift stages per lane, with the four-stage
// remainder units running alongside) and takes one beat every cycle unless
// a stall holds it.
// When the receiver holds hash_ready low with a result waiting, the whole
// pipeline freezes and item_ready drops; nothing is lost or repeated.
// Reset clears both seeds to zero and empties the pipeline.
`include "assert_macros.svh"

module seeded_coordinate_hash (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [csh_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [63:0]                      cfg_data,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  logic                             kind,
	input  logic signed [31:0]               coord_x,
	input  logic signed [31:0]               coord_y,
	input  logic signed [31:0]               coord_z,
	input  logic signed [31:0]               coord_time,
	output logic                             hash_valid,
	input  logic                             hash_ready,
	output logic [63:0]                      hash_value
);
	import csh_pkg::*;

	logic [63:0] seed_primary_q, seed_secondary_q;
	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic kind_s1, kind_s2, kind_s3, kind_s4;
	logic [5:0] vld_all;
	logic [63:0] p_lane, q_lane, p_mixed, q_mixed;
	csh_shifts_t p_sh, q_sh;

	logic [$clog2(P_MOD_X)-1:0] rem_px;
	logic [$clog2(P_MOD_Y)-1:0] rem_py;
	logic [$clog2(P_MOD_Z)-1:0] rem_pz;
	logic [$clog2(P_MOD_T)-1:0] rem_pt;
	logic [$clog2(Q_MOD_X)-1:0] rem_qx;
	logic [$clog2(Q_MOD_Y)-1:0] rem_qy;
	logic [$clog2(Q_MOD_Z)-1:0] rem_qz;
	logic [$clog2(Q_MOD_T)-1:0] rem_qt;

	assign cfg_ready = 1'b1;
	assign en = !vld_s6 || hash_ready;
	assign item_ready = en;
	assign hash_valid = vld_s6;
	assign vld_all = {vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_primary_q <= 64'd0;
			seed_secondary_q <= 64'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SEED_PRIMARY: seed_primary_q <= cfg_data;
				REG_SEED_SECONDARY: seed_secondary_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= item_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= kind;
			kind_s2 <= kind_s1;
			kind_s3 <= kind_s2;
			kind_s4 <= kind_s3;
		end
	end

	csh_sum u_sum (
		.clk            (clk),
		.en             (en),
		.kind           (kind),
		.coord_x        (coord_x),
		.coord_y        (coord_y),
		.coord_z        (coord_z),
		.coord_time     (coord_time),
		.seed_primary   (seed_primary_q),
		.seed_secondary (seed_secondary_q),
		.p_lane         (p_lane),
		.q_lane         (q_lane)
	);

	csh_mod #(.MODULUS(P_MOD_X)) u_mod_px (
		.clk(clk), .en(en), .value_in(coord_x[30:0]), .rem_out(rem_px)
	);
	csh_mod #(.MODULUS(P_MOD_Y)) u_mod_py (
		.clk(clk), .en(en), .value_in(coord_y[30:0]), .rem_out(rem_py)
	);
	csh_mod #(.MODULUS(P_MOD_Z)) u_mod_pz (
		.clk(clk), .en(en), .value_in(coord_z[30:0]), .rem_out(rem_pz)
	);
	csh_mod #(.MODULUS(P_MOD_T)) u_mod_pt (
		.clk(clk), .en(en), .value_in({4'd0, coord_time[26:0]}), .rem_out(rem_pt)
	);
	csh_mod #(.MODULUS(Q_MOD_X)) u_mod_qx (
		.clk(clk), .en(en), .value_in(coord_x[30:0]), .rem_out(rem_qx)
	);
	csh_mod #(.MODULUS(Q_MOD_Y)) u_mod_qy (
		.clk(clk), .en(en), .value_in(coord_y[30:0]), .rem_out(rem_qy)
	);
	csh_mod #(.MODULUS(Q_MOD_Z)) u_mod_qz (
		.clk(clk), .en(en), .value_in(coord_z[30:0]), .rem_out(rem_qz)
	);
	csh_mod #(.MODULUS(Q_MOD_T)) u_mod_qt (
		.clk(clk), .en(en), .value_in(coord_time[30:0]), .rem_out(rem_qt)
	);

	// In three-coordinate mode the time-dependent shifts fall back to their offsets.
	always_comb begin
		p_sh.sh1 = SHIFT_W'(rem_px) + P_OFF_X;
		p_sh.sh2 = SHIFT_W'(rem_py) + P_OFF_Y;
		p_sh.sh3 = SHIFT_W'(rem_pz) + P_OFF_Z;
		p_sh.sh4 = kind_s4 ? SHIFT_W'(rem_pt) + P_OFF_T : P_OFF_T;
		q_sh.sh1 = SHIFT_W'(rem_qx) + Q_OFF_X;
		q_sh.sh2 = SHIFT_W'(rem_qy) + Q_OFF_Y;
		q_sh.sh3 = SHIFT_W'(rem_qz) + Q_OFF_Z;
		q_sh.sh4 = kind_s4 ? SHIFT_W'(rem_qt) + Q_OFF_T : Q_OFF_T;
	end

	csh_mix u_mix_p (
		.clk      (clk),
		.en       (en),
		.lane_in  (p_lane),
		.shifts   (p_sh),
		.lane_out (p_mixed)
	);

	csh_mix u_mix_q (
		.clk      (clk),
		.en       (en),
		.lane_in  (q_lane),
		.shifts   (q_sh),
		.lane_out (q_mixed)
	);

	assign hash_value = p_mixed ^ q_mixed;

	`CSH_ASSERT_NXT(a_accept_enters, clk, arst_n, item_valid && item_ready, vld_s1)
	`CSH_ASSERT_NXT(a_stall_freezes, clk, arst_n, hash_valid && !hash_ready, $stable(vld_all))
	`CSH_ASSERT_IMP(a_p_shift_range, clk, arst_n, vld_s4, p_sh.sh1 >= 6'd5 && p_sh.sh2 <= 6'd38 && p_sh.sh4 >= 6'd45 && p_sh.sh4 <= 6'd61)
	`CSH_ASSERT_IMP(a_q_shift_range, clk, arst_n, vld_s4, q_sh.sh1 <= 6'd41 && q_sh.sh3 <= 6'd41 && q_sh.sh4 >= 6'd11 && q_sh.sh4 <= 6'd53)

endmodule

@@ rtl/csh_mod.sv @@
module csh_mod #(
	parameter int unsigned MODULUS = 7
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [30:0]                  value_in,
	output logic [$clog2(MODULUS)-1:0]   rem_out
);
	localparam int KTOP = 31 - $clog2(MODULUS + 1);

	logic [30:0] r_s1, r_s2, r_s3, r_s4;

	function automatic logic [30:0] reduce(input logic [30:0] r_in, input int hi, input int lo);
		logic [30:0] r;
		logic [30:0] cand;
		r = r_in;
		for (int k = 28; k >= 0; k--) begin
			cand = 31'(MODULUS) << k;
			if (k <= hi && k >= lo && k <= KTOP) begin
				if (r >= cand) begin
					r = r - cand;
				end
			end
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= reduce(value_in, 28, 21);
			r_s2 <= reduce(r_s1, 20, 14);
			r_s3 <= reduce(r_s2, 13, 7);
			r_s4 <= reduce(r_s3, 6, 0);
		end
	end

	assign rem_out = r_s4[$clog2(MODULUS)-1:0];

endmodule

@@ rtl/csh_sum.sv @@
module csh_sum (
	input  logic               clk,
	input  logic               en,
	input  logic               kind,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic signed [31:0] coord_time,
	input  logic [63:0]        seed_primary,
	input  logic [63:0]        seed_secondary,
	output logic [63:0]        p_lane,
	output logic [63:0]        q_lane
);
	import csh_pkg::*;

	logic [63:0] px_s1, py_s1, pz_s1, pt_s1;
	logic [63:0] qx_s1, qy_s1, qz_s1, qt_s1;
	logic [63:0] pa_s2, pb_s2, qa_s2, qb_s2;
	logic [63:0] p_s3, q_s3, p_s4, q_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= mul_ext(coord_x, P_MUL_X);
			py_s1 <= mul_ext(coord_y, P_MUL_Y);
			pz_s1 <= mul_ext(coord_z, P_MUL_Z);
			pt_s1 <= kind ? mul_ext(coord_time, P_MUL_T) : 64'd0;
			qx_s1 <= mul_ext(coord_x, Q_MUL_X);
			qy_s1 <= mul_ext(coord_y, Q_MUL_Y);
			qz_s1 <= mul_ext(coord_z, Q_MUL_Z);
			qt_s1 <= kind ? mul_ext(coord_time, Q_MUL_T) : 64'd0;

			pa_s2 <= seed_primary + px_s1 + py_s1;
			pb_s2 <= pz_s1 + pt_s1;
			qa_s2 <= seed_secondary + qx_s1 + qy_s1;
			qb_s2 <= qz_s1 + qt_s1;

			p_s3 <= pa_s2 + pb_s2;
			q_s3 <= qa_s2 + qb_s2;

			p_s4 <= p_s3;
			q_s4 <= q_s3;
		end
	end

	assign p_lane = p_s4;
	assign q_lane = q_s4;

endmodule

@@ rtl/csh_mix.sv @@
module csh_mix (
	input  logic                 clk,
	input  logic                 en,
	input  logic [63:0]          lane_in,
	input  csh_pkg::csh_shifts_t shifts,
	output logic [63:0]          lane_out
);
	import csh_pkg::*;

	logic [63:0] v1, v2, v3, v4;
	logic [63:0] v_s5, v_s6;
	logic [SHIFT_W-1:0] sh3_s5, sh4_s5;

	always_comb begin
		v1 = lane_in ^ (lane_in << shifts.sh1);
		v2 = v1 ^ shr_arith(v1, shifts.sh2);
		v3 = v_s5 ^ (v_s5 << sh3_s5);
		v4 = v3 ^ shr_arith(v3, sh4_s5);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s5 <= v2;
			sh3_s5 <= shifts.sh3;
			sh4_s5 <= shifts.sh4;
			v_s6 <= v4;
		end
	end

	assign lane_out = v_s6;

endmodule
